>>> rtl/rpge_pkg.sv
// Shared types, constants and helpers for the raster patch growth engine.
// No dependencies.
package rpge_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DIM_W      = 7;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_REBUILD = 2'd1;
    localparam logic [1:0] CMD_GROW    = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [1:0] CELL_FREE    = 2'd0;
    localparam logic [1:0] CELL_PATCH   = 2'd1;
    localparam logic [1:0] CELL_BARRIER = 2'd2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_NBR  = 2'd2;
    localparam logic [1:0] REG_GROW = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic             nbr8;
        logic             circ;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [1:0]       state;
        logic [CNT_W-1:0] count;
        logic             grew;
    } res_t;

    typedef struct packed {
        logic signed [1:0] dr;
        logic signed [1:0] dc;
    } delta_t;

    // neighbour offsets; 8-mode goes column-major
    function automatic delta_t nb_delta(input logic [2:0] k, input logic nbr8);
        delta_t d;
        d = '{dr: 2'sd0, dc: 2'sd0};
        if (nbr8)
        begin
            case (k)
                3'd0: d = '{dr: -2'sd1, dc: -2'sd1};
                3'd1: d = '{dr:  2'sd0, dc: -2'sd1};
                3'd2: d = '{dr:  2'sd1, dc: -2'sd1};
                3'd3: d = '{dr: -2'sd1, dc:  2'sd0};
                3'd4: d = '{dr:  2'sd1, dc:  2'sd0};
                3'd5: d = '{dr: -2'sd1, dc:  2'sd1};
                3'd6: d = '{dr:  2'sd0, dc:  2'sd1};
                default: d = '{dr: 2'sd1, dc: 2'sd1};
            endcase
        end
        else
        begin
            case (k[1:0])
                2'd0: d = '{dr:  2'sd0, dc: -2'sd1};
                2'd1: d = '{dr:  2'sd0, dc:  2'sd1};
                2'd2: d = '{dr: -2'sd1, dc:  2'sd0};
                default: d = '{dr: 2'sd1, dc: 2'sd0};
            endcase
        end
        return d;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > mx)
            r = mx;
        return r;
    endfunction

endpackage

>>> rtl/raster_patch_growth_engine_core.sv
// Top level: configuration registers, result register, memories and sequencer.
// Depends on rpge_pkg, rpge_ram and rpge_ctrl.
// Sequencing: write/read access the cell; growth removes a picked list entry and, unless circ
//   is set, lists its free in-grid neighbours; rebuild scans every cell and its neighbours.
// Throughput: one command at a time, set by the single port of the cell memory.
// Reset: rst_n asynchronous; a clearing sweep frees the grid first.
module raster_patch_growth_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // mode, cell_row, cell_col, cell_value, random_fraction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_row, out_col, out_state, border_count, grew, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import rpge_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic              oval_reg, oval_next;
    res_t              out_reg, out_next;
    logic              res_valid, res_ready;
    res_t              res;
    logic [ADDR_W-1:0] cell_addr, list_addr, list_wdata, list_rdata;
    logic              cell_we, list_we;
    logic [2:0]        cell_wdata, cell_rdata;

    assign cfg_ready     = 1'b1;
    assign res_ready     = !oval_reg || m_axis_tready;
    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = {4'd0, out_reg.grew, out_reg.count, out_reg.state,
                            out_reg.col, out_reg.row};

    always_comb
    begin
        cfg_next  = cfg_reg;
        oval_next = oval_reg;
        out_next  = out_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROWS: cfg_next.rows = cfg_data;
                REG_COLS: cfg_next.cols = cfg_data;
                REG_NBR:  cfg_next.nbr8 = cfg_data[0];
                REG_GROW: cfg_next.circ = cfg_data[0];
                default:  cfg_next = cfg_reg;
            endcase
        end
        if (m_axis_tready)
            oval_next = 1'b0;
        if (res_valid && res_ready)
        begin
            oval_next = 1'b1;
            out_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '{rows: DIM_W'(MAX_ROWS), cols: DIM_W'(MAX_COLS),
                          nbr8: 1'b0, circ: 1'b0};
            oval_reg <= 1'b0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    rpge_ram #(.WIDTH(3), .ADDR_W(ADDR_W)) u_cell_mem (
        .clk   (clk),
        .addr  (cell_addr),
        .we    (cell_we),
        .wdata (cell_wdata),
        .rdata (cell_rdata)
    );

    rpge_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_list_mem (
        .clk   (clk),
        .addr  (list_addr),
        .we    (list_we),
        .wdata (list_wdata),
        .rdata (list_rdata)
    );

    rpge_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cell_addr  (cell_addr),
        .cell_we    (cell_we),
        .cell_wdata (cell_wdata),
        .cell_rdata (cell_rdata),
        .list_addr  (list_addr),
        .list_we    (list_we),
        .list_wdata (list_wdata),
        .list_rdata (list_rdata)
    );
endmodule

>>> rtl/rpge_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module rpge_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic [ADDR_W-1:0] addr,
    input  logic              we,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> rtl/rpge_ctrl.sv
// Command sequencer: clearing sweep, cell access, growth step, border rebuild.
// Depends on rpge_pkg; drives the cell memory and the border list memory.
module rpge_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rpge_pkg::cfg_t            cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               in_data,
    output logic                      res_valid,
    input  logic                      res_ready,
    output rpge_pkg::res_t            res,
    output logic [rpge_pkg::ADDR_W-1:0] cell_addr,
    output logic                      cell_we,
    output logic [2:0]                cell_wdata,
    input  logic [2:0]                cell_rdata,
    output logic [rpge_pkg::ADDR_W-1:0] list_addr,
    output logic                      list_we,
    output logic [rpge_pkg::ADDR_W-1:0] list_wdata,
    input  logic [rpge_pkg::ADDR_W-1:0] list_rdata
);
    import rpge_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CELL_A = 4'd2;
    localparam logic [3:0] S_CELL_B = 4'd3;
    localparam logic [3:0] S_PICK   = 4'd4;
    localparam logic [3:0] S_GA     = 4'd5;
    localparam logic [3:0] S_GB     = 4'd6;
    localparam logic [3:0] S_GC     = 4'd7;
    localparam logic [3:0] S_NB_A   = 4'd8;
    localparam logic [3:0] S_NB_B   = 4'd9;
    localparam logic [3:0] S_RB_A   = 4'd10;
    localparam logic [3:0] S_RB_B   = 4'd11;
    localparam logic [3:0] S_RB_NA  = 4'd12;
    localparam logic [3:0] S_RB_NB  = 4'd13;
    localparam logic [3:0] S_RB_W   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_TOTAL - 1);

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        k_reg, k_next;
    logic              hit_reg, hit_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [1:0]        val_reg, val_next;
    logic [15:0]       frac_reg, frac_next;
    logic [ADDR_W-1:0] pick_reg, pick_next;
    logic [ADDR_W-1:0] cell_reg, cell_next;
    res_t              res_reg, res_next;

    logic [DIM_W-1:0]  nr, nc;
    logic [ADDR_W-1:0] ctr;
    delta_t            dl;
    logic [DIM_W-1:0]  nb_row, nb_col;
    logic              nb_ok;
    logic [ADDR_W-1:0] nb_idx;
    logic              k_last;
    logic              scan_act;
    logic [CNT_W+15:0] prod;

    assign nr = clamp_dim(cfg.rows, DIM_W'(MAX_ROWS));
    assign nc = clamp_dim(cfg.cols, DIM_W'(MAX_COLS));
    assign ctr = (state_reg inside {S_RB_NA, S_RB_NB}) ? scan_reg : cell_reg;
    assign dl = nb_delta(k_reg, cfg.nbr8);
    assign nb_row = DIM_W'({1'b0, ctr[ADDR_W-1:COL_W]}) + DIM_W'(signed'(dl.dr));
    assign nb_col = DIM_W'({1'b0, ctr[COL_W-1:0]}) + DIM_W'(signed'(dl.dc));
    assign nb_ok = (nb_row < nr) && (nb_col < nc);
    assign nb_idx = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
    assign k_last = cfg.nbr8 ? (k_reg == 3'd7) : (k_reg == 3'd3);
    assign scan_act = (DIM_W'(scan_reg[ADDR_W-1:COL_W]) < nr)
                      && (DIM_W'(scan_reg[COL_W-1:0]) < nc);
    assign prod = frac_reg * count_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{row: res_reg.row, col: res_reg.col, state: res_reg.state,
                         count: count_reg, grew: res_reg.grew};

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        count_next = count_reg;
        k_next     = k_reg;
        hit_next   = hit_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        frac_next  = frac_reg;
        pick_next  = pick_reg;
        cell_next  = cell_reg;
        res_next   = res_reg;
        cell_addr  = scan_reg;
        cell_we    = 1'b0;
        cell_wdata = '0;
        list_addr  = pick_reg;
        list_we    = 1'b0;
        list_wdata = '0;
        case (state_reg)
            S_CLR:
            begin
                cell_we   = 1'b1;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = in_data[1:0];
                    pos_next  = {in_data[7:2], in_data[13:8]};
                    val_next  = (in_data[15:14] == 2'd3) ? CELL_BARRIER : in_data[15:14];
                    frac_next = in_data[31:16];
                    res_next  = '0;
                    case (in_data[1:0])
                        CMD_REBUILD:
                        begin
                            count_next = '0;
                            scan_next  = '0;
                            state_next = S_RB_A;
                        end
                        CMD_GROW:
                            state_next = (count_reg == '0) ? S_DONE : S_PICK;
                        default:
                            state_next = S_CELL_A;
                    endcase
                end
            end
            S_CELL_A:
            begin
                cell_addr  = pos_reg;
                state_next = S_CELL_B;
            end
            S_CELL_B:
            begin
                cell_addr   = pos_reg;
                res_next.row = pos_reg[ADDR_W-1:COL_W];
                res_next.col = pos_reg[COL_W-1:0];
                if (cmd_reg == CMD_WRITE)
                begin
                    cell_we        = 1'b1;
                    cell_wdata     = {cell_rdata[2], val_reg};
                    res_next.state = val_reg;
                end
                else
                    res_next.state = cell_rdata[1:0];
                state_next = S_DONE;
            end
            S_PICK:
            begin
                pick_next  = prod[ADDR_W+15:16];
                state_next = S_GA;
            end
            S_GA:
            begin
                list_addr  = pick_reg;
                state_next = S_GB;
            end
            S_GB:
            begin
                cell_next  = list_rdata;
                list_addr  = ADDR_W'(count_reg - 1'b1);
                state_next = S_GC;
            end
            S_GC:
            begin
                list_addr      = pick_reg;
                list_we        = 1'b1;
                list_wdata     = list_rdata;
                cell_addr      = cell_reg;
                cell_we        = 1'b1;
                cell_wdata     = {1'b0, CELL_PATCH};
                count_next     = count_reg - 1'b1;
                res_next.row   = cell_reg[ADDR_W-1:COL_W];
                res_next.col   = cell_reg[COL_W-1:0];
                res_next.state = CELL_PATCH;
                res_next.grew  = 1'b1;
                k_next         = '0;
                if (!cfg.circ)
                    state_next = S_NB_A;
                else if (count_reg == CNT_W'(1))
                begin
                    count_next = '0;
                    scan_next  = '0;
                    state_next = S_RB_A;
                end
                else
                    state_next = S_DONE;
            end
            S_NB_A:
            begin
                cell_addr = nb_idx;
                if (nb_ok)
                    state_next = S_NB_B;
                else if (k_last)
                    state_next = S_DONE;
                else
                    k_next = k_reg + 1'b1;
            end
            S_NB_B:
            begin
                cell_addr = nb_idx;
                if (cell_rdata == {1'b0, CELL_FREE} && !count_reg[CNT_W-1])
                begin
                    cell_we    = 1'b1;
                    cell_wdata = {1'b1, CELL_FREE};
                    list_addr  = count_reg[ADDR_W-1:0];
                    list_we    = 1'b1;
                    list_wdata = nb_idx;
                    count_next = count_reg + 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = k_last ? S_DONE : S_NB_A;
            end
            S_RB_A:
            begin
                cell_addr  = scan_reg;
                state_next = S_RB_B;
            end
            S_RB_B:
            begin
                cell_addr = scan_reg;
                hit_next  = 1'b0;
                k_next    = '0;
                if (scan_act && cell_rdata[1:0] == CELL_FREE)
                    state_next = S_RB_NA;
                else
                begin
                    cell_we    = 1'b1;
                    cell_wdata = {1'b0, cell_rdata[1:0]};
                    scan_next  = scan_reg + 1'b1;
                    state_next = (scan_reg == LAST_ADDR) ? S_DONE : S_RB_A;
                end
            end
            S_RB_NA:
            begin
                cell_addr = nb_idx;
                if (nb_ok)
                    state_next = S_RB_NB;
                else if (k_last)
                    state_next = S_RB_W;
                else
                    k_next = k_reg + 1'b1;
            end
            S_RB_NB:
            begin
                cell_addr = nb_idx;
                k_next    = k_reg + 1'b1;
                if (cell_rdata[1:0] == CELL_PATCH)
                begin
                    hit_next   = 1'b1;
                    state_next = S_RB_W;
                end
                else
                    state_next = k_last ? S_RB_W : S_RB_NA;
            end
            S_RB_W:
            begin
                cell_addr  = scan_reg;
                cell_we    = 1'b1;
                cell_wdata = {hit_reg, CELL_FREE};
                if (hit_reg)
                begin
                    list_addr  = count_reg[ADDR_W-1:0];
                    list_we    = 1'b1;
                    list_wdata = scan_reg;
                    count_next = count_reg + 1'b1;
                end
                scan_next  = scan_reg + 1'b1;
                state_next = (scan_reg == LAST_ADDR) ? S_DONE : S_RB_A;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            scan_reg  <= '0;
            count_reg <= '0;
            k_reg     <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        frac_reg <= frac_next;
        pick_reg <= pick_next;
        cell_reg <= cell_next;
        res_reg  <= res_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CELL_TOTAL))
        else $error("border count out of range");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (list_we && state_reg != S_GC) |-> !count_reg[CNT_W-1])
        else $error("append into a full border list");

    a_pick_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GA |-> CNT_W'(pick_reg) < count_reg)
        else $error("selection index reached count");

    a_grow_dec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GC |=> count_reg == $past(count_reg) - 1'b1
                              || state_reg == S_RB_A)
        else $error("growth did not remove an entry");
endmodule

>>> bench/tb_raster_patch_growth_engine_core.sv
// Self-checking bench for raster_patch_growth_engine_core: random and directed commands,
// results predicted by a scoreboard class that keeps its own copy of grid and border list.
// Depends on rpge_pkg and the core RTL.
`timescale 1ns / 100ps

class patch_scoreboard;
    logic [1:0]  grid [4096];
    bit          listed [4096];
    logic [11:0] blist [4096];
    int unsigned cnt;
    int unsigned rows;
    int unsigned cols;
    bit          nbr8;
    bit          circ;
    logic [31:0] due [$];
    int          errors;

    function new();
        for (int i = 0; i < 4096; i++)
        begin
            grid[i] = rpge_pkg::CELL_FREE;
            listed[i] = 0;
            blist[i] = '0;
        end
        cnt = 0;
        rows = 64;
        cols = 64;
        nbr8 = 0;
        circ = 0;
        errors = 0;
    endfunction

    function int unsigned act(int unsigned v);
        if (v == 0)
            return 1;
        if (v > 64)
            return 64;
        return v;
    endfunction

    function bit patch_at(int r, int c);
        if (r < 0 || c < 0 || r >= act(rows) || c >= act(cols))
            return 0;
        return grid[r * 64 + c] == rpge_pkg::CELL_PATCH;
    endfunction

    function void regather();
        bit hit;
        for (int i = 0; i < 4096; i++)
            listed[i] = 0;
        cnt = 0;
        for (int r = 0; r < act(rows); r++)
            for (int c = 0; c < act(cols); c++)
            begin
                if (grid[r * 64 + c] != rpge_pkg::CELL_FREE)
                    continue;
                hit = patch_at(r, c - 1) || patch_at(r, c + 1) ||
                      patch_at(r - 1, c) || patch_at(r + 1, c);
                if (nbr8)
                    hit = hit || patch_at(r - 1, c - 1) || patch_at(r - 1, c + 1) ||
                          patch_at(r + 1, c - 1) || patch_at(r + 1, c + 1);
                if (hit)
                begin
                    blist[cnt] = 12'(r * 64 + c);
                    listed[r * 64 + c] = 1;
                    cnt++;
                end
            end
    endfunction

    function void try_add(int r, int c);
        int a;
        if (r < 0 || c < 0 || r >= act(rows) || c >= act(cols))
            return;
        a = r * 64 + c;
        if (grid[a] != rpge_pkg::CELL_FREE || listed[a] || cnt >= 4096)
            return;
        blist[cnt] = 12'(a);
        listed[a] = 1;
        cnt++;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] v);
        case (idx)
            rpge_pkg::REG_ROWS: rows = v;
            rpge_pkg::REG_COLS: cols = v;
            rpge_pkg::REG_NBR:  nbr8 = v[0];
            default:            circ = v[0];
        endcase
    endfunction

    function void note_cmd(logic [31:0] d);
        logic [1:0]  mode;
        logic [5:0]  r;
        logic [5:0]  c;
        logic [1:0]  v;
        int unsigned frac;
        int unsigned pick;
        int          a;
        logic [5:0]  orow;
        logic [5:0]  ocol;
        logic [1:0]  ost;
        bit          grew;
        mode = d[1:0];
        r = d[7:2];
        c = d[13:8];
        v = d[15:14];
        frac = d[31:16];
        orow = '0;
        ocol = '0;
        ost = rpge_pkg::CELL_FREE;
        grew = 0;
        case (mode)
            rpge_pkg::CMD_WRITE:
            begin
                if (v == 2'd3)
                    v = rpge_pkg::CELL_BARRIER;
                grid[r * 64 + c] = v;
                orow = r;
                ocol = c;
                ost = v;
            end
            rpge_pkg::CMD_REBUILD:
                regather();
            rpge_pkg::CMD_GROW:
                if (cnt > 0)
                begin
                    pick = (frac * cnt) >> 16;
                    a = blist[pick];
                    grid[a] = rpge_pkg::CELL_PATCH;
                    listed[a] = 0;
                    cnt--;
                    blist[pick] = blist[cnt];
                    orow = 6'(a / 64);
                    ocol = 6'(a % 64);
                    ost = rpge_pkg::CELL_PATCH;
                    grew = 1;
                    if (!circ)
                    begin
                        if (!nbr8)
                        begin
                            try_add(orow, ocol - 1);
                            try_add(orow, ocol + 1);
                            try_add(orow - 1, ocol);
                            try_add(orow + 1, ocol);
                        end
                        else
                            for (int dc = -1; dc <= 1; dc++)
                                for (int dr = -1; dr <= 1; dr++)
                                    if (dc != 0 || dr != 0)
                                        try_add(orow + dr, ocol + dc);
                    end
                    else if (cnt == 0)
                        regather();
                end
            default:
            begin
                orow = r;
                ocol = c;
                ost = grid[r * 64 + c];
            end
        endcase
        due.push_back({4'b0, grew, 13'(cnt), ost, ocol, orow});
    endfunction

    function void check_result(logic [31:0] a);
        logic [31:0] e;
        if (due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result transaction %h", a);
            return;
        end
        e = due.pop_front();
        if (a[5:0] != e[5:0] || a[11:6] != e[11:6] || a[13:12] != e[13:12] ||
            a[26:14] != e[26:14] || a[27] != e[27])
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: row %0d/%0d col %0d/%0d state %0d/%0d count %0d/%0d grew %0d/%0d (exp/act)",
                         e[5:0], a[5:0], e[11:6], a[11:6], e[13:12], a[13:12],
                         e[26:14], a[26:14], e[27], a[27]);
        end
    endfunction
endclass

module tb_raster_patch_growth_engine_core;
    import rpge_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // mode, cell_row, cell_col, cell_value, random_fraction
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // out_row, out_col, out_state, border_count, grew, pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    patch_scoreboard sb;
    bit calm;
    bit hold_req;
    int hold_cnt;

    raster_patch_growth_engine_core uut (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("tb_raster_patch_growth_engine_core: errors");
        $finish;
    end

    // result side: checks and back-pressure
    initial
    begin
        m_axis_tready = 0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (hold_req)
            begin
                hold_req = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 0;
            end
            else
                m_axis_tready <= calm || $urandom_range(99) >= 24;
        end
    end

    task automatic send_cmd(input logic [1:0] mode, input logic [5:0] r, input logic [5:0] c,
                            input logic [1:0] v, input logic [15:0] frac);
        while (!calm && $urandom_range(99) < 24)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {frac, v, c, r, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_cmd(s_axis_tdata);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] v);
        s_axis_tvalid <= 0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic configure(input logic [6:0] r, input logic [6:0] c, input bit n8, input bit cm);
        write_reg(REG_ROWS, r);
        write_reg(REG_COLS, c);
        write_reg(REG_NBR, 7'(n8));
        write_reg(REG_GROW, 7'(cm));
    endtask

    // mostly growth on a seeded patch; writes and reads mixed in; rebuilds rationed
    task automatic run_burst(input int n, input int rebuilds, input bit squeeze);
        int          p;
        logic [5:0]  r;
        logic [5:0]  c;
        logic [15:0] f;
        for (int k = 0; k < n; k++)
        begin
            if (squeeze && k == n / 2)
                hold_req = 1;
            p = $urandom_range(99);
            if ($urandom_range(9) == 0)
            begin
                r = 6'($urandom_range(63));
                c = 6'($urandom_range(63));
            end
            else
            begin
                r = 6'($urandom_range(sb.act(sb.rows) - 1));
                c = 6'($urandom_range(sb.act(sb.cols) - 1));
            end
            case ($urandom_range(7))
                0:       f = 16'h0000;
                1:       f = 16'hffff;
                default: f = 16'($urandom_range(65535));
            endcase
            if (sb.cnt == 0 && rebuilds > 0 && p < 50)
            begin
                send_cmd(CMD_WRITE, r, c, CELL_PATCH, f);
                send_cmd(CMD_REBUILD, r, c, 2'($urandom_range(3)), f);
                rebuilds--;
            end
            else if (p < 55)
            begin
                if (sb.circ && sb.cnt == 1)
                begin
                    if (rebuilds > 0)
                    begin
                        rebuilds--;
                        send_cmd(CMD_GROW, r, c, 2'($urandom_range(3)), f);
                    end
                    else
                        send_cmd(CMD_READ, r, c, 2'($urandom_range(3)), f);
                end
                else
                    send_cmd(CMD_GROW, r, c, 2'($urandom_range(3)), f);
            end
            else if (p < 72)
                send_cmd(CMD_WRITE, r, c, 2'($urandom_range(3)), f);
            else if (p < 97 || rebuilds == 0)
                send_cmd(CMD_READ, r, c, 2'($urandom_range(3)), f);
            else
            begin
                send_cmd(CMD_REBUILD, r, c, 2'($urandom_range(3)), f);
                rebuilds--;
            end
        end
    endtask

    initial
    begin
        sb = new();
        calm = 0;
        hold_req = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_valid = 0;
        cfg_index = REG_ROWS;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: corners, write of three, empty-list step, rewrite of a listed cell
        send_cmd(CMD_GROW, 6'd0, 6'd0, CELL_FREE, 16'hffff);
        send_cmd(CMD_WRITE, 6'd0, 6'd0, CELL_PATCH, 16'h0000);
        send_cmd(CMD_WRITE, 6'd0, 6'd1, 2'd3, 16'h0000);
        send_cmd(CMD_WRITE, 6'd63, 6'd63, CELL_PATCH, 16'hffff);
        send_cmd(CMD_WRITE, 6'd63, 6'd62, CELL_FREE, 16'h0000);
        send_cmd(CMD_READ, 6'd0, 6'd1, CELL_FREE, 16'h0000);
        send_cmd(CMD_READ, 6'd63, 6'd63, 2'd3, 16'hffff);
        send_cmd(CMD_REBUILD, 6'd0, 6'd0, CELL_FREE, 16'h0000);
        send_cmd(CMD_WRITE, 6'd1, 6'd0, CELL_BARRIER, 16'h0000);
        send_cmd(CMD_GROW, 6'd0, 6'd0, CELL_FREE, 16'h0000);
        send_cmd(CMD_GROW, 6'd0, 6'd0, CELL_FREE, 16'hffff);
        send_cmd(CMD_READ, 6'd1, 6'd0, CELL_FREE, 16'h0000);
        send_cmd(CMD_GROW, 6'd63, 6'd0, CELL_FREE, 16'h8000);
        send_cmd(CMD_READ, 6'd62, 6'd63, CELL_FREE, 16'h0000);

        run_burst(110, 2, 1);
        configure(7'd127, 7'd0, 1, 0);
        run_burst(40, 2, 0);
        configure(7'd12, 7'd9, 1, 1);
        calm = 1;
        run_burst(60, 2, 0);
        calm = 0;
        run_burst(60, 2, 0);
        configure(7'd5, 7'd64, 0, 1);
        run_burst(60, 2, 0);
        configure(7'd64, 7'd1, 0, 0);
        run_burst(50, 1, 0);

        s_axis_tvalid <= 0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_raster_patch_growth_engine_core: clean");
        else
            $display("tb_raster_patch_growth_engine_core: errors");
        $finish;
    end
endmodule

>>> files.f
rtl/rpge_pkg.sv
rtl/rpge_ram.sv
rtl/rpge_ctrl.sv
rtl/raster_patch_growth_engine_core.sv
bench/tb_raster_patch_growth_engine_core.sv
